### hdl/subsequence_density_counter_top_macros.svh
// ----------------------------------------------------------------------------
// subsequence_density_counter_top_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SUBSEQUENCE_DENSITY_COUNTER_TOP_MACROS_SVH
`define SUBSEQUENCE_DENSITY_COUNTER_TOP_MACROS_SVH

// checked outside reset
`define SDC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked through reset as well
`define SDC_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// Types and constants of the subsequence density counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int SYM_W           = 8;
  localparam int IDX_W           = 3;
  localparam int PLEN_W          = 4;
  localparam int THR_W           = 16;
  localparam int PAT_W           = 64;
  localparam int FIELD_W         = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 4'd1;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd2294;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_SYMBOLS   = 2'd0,
    CFG_PATTERN_LENGTH    = 2'd1,
    CFG_DENSITY_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_sequence;
    logic             first_of_set;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] support_count;
    logic [FIELD_W-1:0] sequence_length;
    logic               dense_enough;
    logic [FIELD_W-1:0] dense_sequences;
    logic [FIELD_W-1:0] sequences_seen;
    logic               any_long_enough;
  } out_t;

endpackage

`default_nettype wire

### hdl/sdc_front.sv
// ----------------------------------------------------------------------------
// sdc_front
// Symbol matcher: advances the pattern pointer, counts occurrences and length,
// and pushes one record per finished sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_front #(
  parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF,
  parameter int REC_W      = 2 * COUNT_BITS + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sdc_pkg::in_t                  in_data,
  input  wire logic [sdc_pkg::PAT_W-1:0]     pattern_symbols,
  input  wire logic [sdc_pkg::PLEN_W-1:0]    pattern_length,
  output logic                               push,
  output logic [REC_W-1:0]                   push_rec,
  input  wire logic                          q_full
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [sdc_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [COUNT_BITS-1:0]      occ_r, occ_nxt;
  logic [COUNT_BITS-1:0]      len_r, len_nxt;
  logic                       clr_r, clr_nxt;

  logic                       accept;
  logic [sdc_pkg::PLEN_W-1:0] plen_eff;
  logic [sdc_pkg::SYM_W-1:0]  want;
  logic                       hit;
  logic                       done;
  logic [COUNT_BITS-1:0]      len_inc;
  logic [COUNT_BITS-1:0]      occ_new;
  logic                       fits;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (pattern_length == '0) begin
      plen_eff = sdc_pkg::PLEN_W'(1);
    end else if (pattern_length > sdc_pkg::PLEN_W'(sdc_pkg::MAX_PATTERN)) begin
      plen_eff = sdc_pkg::PLEN_W'(sdc_pkg::MAX_PATTERN);
    end else begin
      plen_eff = pattern_length;
    end
  end

  assign want    = pattern_symbols[{idx_r, 3'b000} +: sdc_pkg::SYM_W];
  assign hit     = (in_data.symbol == want);
  assign done    = hit && (({1'b0, idx_r} + sdc_pkg::PLEN_W'(1)) >= plen_eff);
  assign len_inc = (len_r == CNT_MAX) ? len_r : len_r + 1'b1;
  assign occ_new = done ? ((occ_r == CNT_MAX) ? occ_r : occ_r + 1'b1) : occ_r;
  assign fits    = (len_inc >= {{(COUNT_BITS - sdc_pkg::PLEN_W){1'b0}}, plen_eff});

  assign push     = accept && in_data.last_of_sequence;
  assign push_rec = {clr_r | in_data.first_of_set, fits, occ_new, len_inc};

  always_comb begin
    idx_nxt = idx_r;
    occ_nxt = occ_r;
    len_nxt = len_r;
    clr_nxt = clr_r;
    if (accept) begin
      if (in_data.last_of_sequence) begin
        idx_nxt = '0;
        occ_nxt = '0;
        len_nxt = '0;
        clr_nxt = 1'b0;
      end else begin
        occ_nxt = occ_new;
        len_nxt = len_inc;
        clr_nxt = clr_r | in_data.first_of_set;
        if (hit) begin
          idx_nxt = done ? '0 : idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      occ_r <= '0;
      len_r <= '0;
      clr_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      occ_r <= occ_nxt;
      len_r <= len_nxt;
      clr_r <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sdc_queue.sv
// ----------------------------------------------------------------------------
// sdc_queue
// Small first-in first-out store of sequence records.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_queue #(
  parameter int DATA_W = 34,
  parameter int DEPTH  = sdc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output logic [DATA_W-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sdc_back.sv
// ----------------------------------------------------------------------------
// sdc_back
// Density stage: threshold product, density compare, set totals and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_back #(
  parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF,
  parameter int REC_W      = 2 * COUNT_BITS + 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [sdc_pkg::THR_W-1:0]  density_threshold,
  input  wire logic                       head_valid,
  input  wire logic [REC_W-1:0]           head_data,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sdc_pkg::out_t                   out_data
);

  localparam int PROD_W = sdc_pkg::THR_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  a_valid_r, a_valid_nxt;
  logic [REC_W-1:0]      a_rec_r;
  logic [PROD_W-1:0]     a_prod_r;

  logic                  a_clr;
  logic                  a_fits;
  logic [COUNT_BITS-1:0] a_occ;
  logic [COUNT_BITS-1:0] a_len;

  logic [COUNT_BITS-1:0] dense_r, dense_nxt;
  logic [COUNT_BITS-1:0] seen_r, seen_nxt;
  logic                  fits_r, fits_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sdc_pkg::out_t         out_data_r, out_data_nxt;

  logic                  b_load;
  logic                  dense;
  logic [COUNT_BITS-1:0] dense_base;
  logic [COUNT_BITS-1:0] seen_base;

  assign b_load = a_valid_r && (!out_valid_r || out_ready);
  assign pop    = head_valid && (!a_valid_r || b_load);

  assign {a_clr, a_fits, a_occ, a_len} = a_rec_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      a_rec_r  <= head_data;
      a_prod_r <= PROD_W'(density_threshold) * PROD_W'(head_data[COUNT_BITS-1:0]);
    end
  end

  assign dense      = ({a_occ, {sdc_pkg::THR_W{1'b0}}} >= a_prod_r);
  assign dense_base = a_clr ? '0 : dense_r;
  assign seen_base  = a_clr ? '0 : seen_r;

  always_comb begin
    a_valid_nxt   = a_valid_r;
    dense_nxt     = dense_r;
    seen_nxt      = seen_r;
    fits_nxt      = fits_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (b_load) begin
      a_valid_nxt = 1'b0;
      dense_nxt   = dense ? ((dense_base == CNT_MAX) ? dense_base : dense_base + 1'b1)
                          : dense_base;
      seen_nxt    = (seen_base == CNT_MAX) ? seen_base : seen_base + 1'b1;
      fits_nxt    = (fits_r && !a_clr) || a_fits;
      out_valid_nxt                = 1'b1;
      out_data_nxt.support_count   = sdc_pkg::FIELD_W'(a_occ);
      out_data_nxt.sequence_length = sdc_pkg::FIELD_W'(a_len);
      out_data_nxt.dense_enough    = dense;
      out_data_nxt.dense_sequences = sdc_pkg::FIELD_W'(dense_nxt);
      out_data_nxt.sequences_seen  = sdc_pkg::FIELD_W'(seen_nxt);
      out_data_nxt.any_long_enough = fits_nxt;
    end
    if (pop) begin
      a_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      dense_r     <= '0;
      seen_r      <= '0;
      fits_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      dense_r     <= dense_nxt;
      seen_r      <= seen_nxt;
      fits_r      <= fits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/subsequence_density_counter_top.sv
// ----------------------------------------------------------------------------
// subsequence_density_counter_top
// Counts greedy non-overlapping pattern occurrences per sequence and reports
// support, length, density flag and per-set totals at each sequence end.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   in      | in_valid / in_ready  | in_data  (symbol, last, first)
//   out     | out_valid / out_ready| out_data (support .. any_long)
//   cfg     | cfg_wr_en            | cfg_index, cfg_wr_data
//
// One symbol per cycle while the record queue has room; the matcher pointer
// is registered. Each result passes from its final symbol through the record
// queue, the threshold multiply register and the result register.
// The matcher stalls only when the four-entry record queue is full.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module subsequence_density_counter_top #(
  parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sdc_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sdc_pkg::out_t                        out_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sdc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

  localparam int REC_W = 2 * COUNT_BITS + 2;

  logic [sdc_pkg::PAT_W-1:0]  pattern_r;
  logic [sdc_pkg::PLEN_W-1:0] plen_r;
  logic [sdc_pkg::THR_W-1:0]  thr_r;

  logic             push;
  logic [REC_W-1:0] push_rec;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  logic [REC_W-1:0] head_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= sdc_pkg::PLEN_RESET;
      thr_r     <= sdc_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sdc_pkg::CFG_PATTERN_SYMBOLS: begin
          pattern_r <= cfg_wr_data[sdc_pkg::PAT_W-1:0];
        end
        sdc_pkg::CFG_PATTERN_LENGTH: begin
          plen_r <= cfg_wr_data[sdc_pkg::PLEN_W-1:0];
        end
        sdc_pkg::CFG_DENSITY_THRESHOLD: begin
          thr_r <= cfg_wr_data[sdc_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sdc_front #(
    .COUNT_BITS (COUNT_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .pattern_symbols (pattern_r),
    .pattern_length  (plen_r),
    .push            (push),
    .push_rec        (push_rec),
    .q_full          (q_full)
  );

  sdc_queue #(
    .DATA_W (REC_W),
    .DEPTH  (sdc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  sdc_back #(
    .COUNT_BITS (COUNT_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .density_threshold (thr_r),
    .head_valid        (head_valid),
    .head_data         (head_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule

`default_nettype wire

### hdl/sdc_checker.sv
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks of the subsequence density counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "subsequence_density_counter_top_macros.svh"

module sdc_checker #(
  parameter int COUNT_BITS = sdc_pkg::COUNT_BITS_DEF
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire sdc_pkg::out_t out_data
);

  localparam logic WIDE = (COUNT_BITS > sdc_pkg::FIELD_W);

  `SDC_CHECK_RST(a_no_out_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `SDC_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped")
  `SDC_CHECK(a_len_nonzero, out_valid |-> WIDE || out_data.sequence_length != '0, "zero length")
  `SDC_CHECK(a_dense_le_seen, out_valid |-> WIDE || (out_data.dense_sequences <= out_data.sequences_seen && out_data.support_count <= out_data.sequence_length), "totals out of order")

endmodule

bind subsequence_density_counter_top sdc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_sdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
